@@ sv/shell_mass_accumulator_defines.svh @@
`ifndef SHELL_MASS_ACCUMULATOR_DEFINES_SVH
`define SHELL_MASS_ACCUMULATOR_DEFINES_SVH

// check a same-cycle implication, clocked by aclk, off during reset
`define SMA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shell_mass_accumulator: same-cycle check failed");

// check an implication in the next cycle, clocked by aclk, off during reset
`define SMA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shell_mass_accumulator: next-cycle check failed");

`endif

@@ sv/sma_pkg.sv @@
package sma_pkg;

    localparam int POS_BITS_DEF  = 24;
    localparam int MASS_BITS_DEF = 32;

    localparam int CFG_W     = 44;
    localparam int CFG_IDX_W = 2;
    localparam int RSQ_W     = 44;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;

    localparam int SHIFT_R2 = 2;
    localparam int SHIFT_R4 = 4;
    localparam int SHIFT_R8 = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_CENTER_Z  = 2'd2,
        REG_RADIUS_SQ = 2'd3
    } sma_reg_t;

    typedef struct packed {
        logic r1;
        logic r2;
        logic r4;
        logic r8;
    } sma_hits_t;

    typedef struct packed {
        logic      valid;
        logic      last;
        sma_hits_t hits;
    } sma_ctl_t;

endpackage

@@ sv/sma_dist.sv @@
module sma_dist
    import sma_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int MASS_BITS = MASS_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [POS_BITS-1:0]  in_px,
    input  logic [POS_BITS-1:0]  in_py,
    input  logic [POS_BITS-1:0]  in_pz,
    input  logic [MASS_BITS-1:0] in_pmass,
    input  logic                 in_last,
    input  logic [POS_BITS-1:0]  center_x,
    input  logic [POS_BITS-1:0]  center_y,
    input  logic [POS_BITS-1:0]  center_z,
    input  logic [RSQ_W-1:0]     radius_sq,
    output sma_ctl_t             out_ctl,
    output logic [MASS_BITS-1:0] out_mass
);

    localparam int DIF_W = POS_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int D2_W  = SQ_W + 2;
    localparam int CMP_W = (D2_W > RSQ_W + SHIFT_R8) ? D2_W : RSQ_W + SHIFT_R8;

    logic [POS_BITS-1:0]     pos [3];
    logic [POS_BITS-1:0]     ctr [3];
    logic signed [DIF_W-1:0] diff [3];
    logic [DIF_W-1:0]        adiff_next [3];
    logic [DIF_W-1:0]        adiff_reg [3];
    logic [SQ_W-1:0]         sq_reg [3];
    logic [D2_W-1:0]         d2;
    logic [CMP_W-1:0]        d2_ext;
    logic [CMP_W-1:0]        thr_r1;
    logic [CMP_W-1:0]        thr_r2;
    logic [CMP_W-1:0]        thr_r4;
    logic [CMP_W-1:0]        thr_r8;
    sma_hits_t               hits_next;

    logic                    valid1_reg;
    logic                    valid2_reg;
    logic                    valid3_reg;
    logic                    last1_reg;
    logic                    last2_reg;
    logic                    last3_reg;
    sma_hits_t               hits_reg;
    logic [MASS_BITS-1:0]    mass1_reg;
    logic [MASS_BITS-1:0]    mass2_reg;
    logic [MASS_BITS-1:0]    mass3_reg;

    assign pos[0] = in_px;
    assign pos[1] = in_py;
    assign pos[2] = in_pz;
    assign ctr[0] = center_x;
    assign ctr[1] = center_y;
    assign ctr[2] = center_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = $signed({pos[i][POS_BITS-1], pos[i]})
                    - $signed({ctr[i][POS_BITS-1], ctr[i]});
            adiff_next[i] = diff[i][DIF_W-1] ? DIF_W'(-diff[i]) : DIF_W'(diff[i]);
        end
    end

    always_comb begin
        d2 = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        d2_ext = CMP_W'(d2);
        thr_r1 = CMP_W'(radius_sq);
        thr_r2 = CMP_W'(radius_sq) << SHIFT_R2;
        thr_r4 = CMP_W'(radius_sq) << SHIFT_R4;
        thr_r8 = CMP_W'(radius_sq) << SHIFT_R8;
        hits_next.r1 = d2_ext < thr_r1;
        hits_next.r2 = d2_ext < thr_r2;
        hits_next.r4 = d2_ext < thr_r4;
        hits_next.r8 = d2_ext < thr_r8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
        end else if (en) begin
            valid1_reg    <= in_valid;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= valid2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                adiff_reg[i] <= adiff_next[i];
                sq_reg[i]    <= adiff_reg[i] * adiff_reg[i];
            end
            mass1_reg     <= in_pmass;
            mass2_reg     <= mass1_reg;
            mass3_reg     <= mass2_reg;
            last1_reg     <= in_last;
            last2_reg     <= last1_reg;
            last3_reg     <= last2_reg;
            hits_reg      <= hits_next;
        end
    end

    always_comb begin
        out_ctl.valid = valid3_reg;
        out_ctl.last  = last3_reg;
        out_ctl.hits  = hits_reg;
    end

    assign out_mass = mass3_reg;

endmodule

@@ sv/sma_accum.sv @@
module sma_accum
    import sma_pkg::*;
#(
    parameter int MASS_BITS = MASS_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  sma_ctl_t             in_ctl,
    input  logic [MASS_BITS-1:0] in_mass,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [SUM_W-1:0]     out_mass_r1,
    output logic [SUM_W-1:0]     out_mass_r2,
    output logic [SUM_W-1:0]     out_mass_r4,
    output logic [SUM_W-1:0]     out_mass_r8,
    output logic [CNT_W-1:0]     out_count
);

    logic [3:0]       hit;
    logic [SUM_W:0]   add [4];
    logic [SUM_W-1:0] sum_next [4];
    logic [SUM_W-1:0] sum_reg [4];
    logic [CNT_W:0]   cnt_add;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             take;
    logic             load;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg [4];
    logic [CNT_W-1:0] out_count_reg;

    assign hit  = {in_ctl.hits.r8, in_ctl.hits.r4, in_ctl.hits.r2, in_ctl.hits.r1};
    assign take = en && in_ctl.valid;
    assign load = take && in_ctl.last;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            add[i]      = {1'b0, sum_reg[i]} + (SUM_W + 1)'(in_mass);
            sum_next[i] = !hit[i]     ? sum_reg[i] :
                          add[i][SUM_W] ? {SUM_W{1'b1}} : add[i][SUM_W-1:0];
        end
        cnt_add  = {1'b0, cnt_reg} + (CNT_W + 1)'(1);
        cnt_next = !hit[0]          ? cnt_reg :
                   cnt_add[CNT_W]   ? {CNT_W{1'b1}} : cnt_add[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                sum_reg[i] <= '0;
            end
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                for (int i = 0; i < 4; i++) begin
                    sum_reg[i] <= in_ctl.last ? '0 : sum_next[i];
                end
                cnt_reg <= in_ctl.last ? '0 : cnt_next;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 4; i++) begin
                out_sum_reg[i] <= sum_next[i];
            end
            out_count_reg <= cnt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_mass_r1 = out_sum_reg[0];
    assign out_mass_r2 = out_sum_reg[1];
    assign out_mass_r4 = out_sum_reg[2];
    assign out_mass_r8 = out_sum_reg[3];
    assign out_count   = out_count_reg;

endmodule

@@ sv/shell_mass_accumulator.sv @@
// Spherical aperture mass sums around a programmed halo centre. Program the
// centre and R^2 through the write port while no particle is in flight, then
// stream particles, one transaction per cycle. Each particle's squared distance
// is tested against R^2, 4R^2, 16R^2 and 64R^2; its mass is added to every
// sphere that holds it and particles inside R are counted, all saturating.
// The particle flagged last closes the halo: one result carrying the four sums
// and the count is registered once that particle has passed the difference,
// square and shell compare registers (the first loaded on the accepting edge)
// and the accumulator's result registers, and the sums restart from zero.
// Throughput is one particle per cycle; the whole pipeline holds, and s_ready
// drops, only while a closing particle reaches the accumulator and the
// previous result still waits with m_ready low.
`include "shell_mass_accumulator_defines.svh"

module shell_mass_accumulator
    import sma_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int MASS_BITS = MASS_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [POS_BITS-1:0]  s_px,
    input  logic [POS_BITS-1:0]  s_py,
    input  logic [POS_BITS-1:0]  s_pz,
    input  logic [MASS_BITS-1:0] s_pmass,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SUM_W-1:0]     m_mass_r1,
    output logic [SUM_W-1:0]     m_mass_r2,
    output logic [SUM_W-1:0]     m_mass_r4,
    output logic [SUM_W-1:0]     m_mass_r8,
    output logic [CNT_W-1:0]     m_inner_count
);

    logic [POS_BITS-1:0]  center_x_reg;
    logic [POS_BITS-1:0]  center_y_reg;
    logic [POS_BITS-1:0]  center_z_reg;
    logic [RSQ_W-1:0]     radius_sq_reg;
    logic                 en;
    sma_ctl_t             dst_ctl;
    logic [MASS_BITS-1:0] dst_mass;
    logic                 hits_outer;
    logic                 sums_ordered;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_sq_reg <= '0;
        end else if (cfg_we) begin
            case (sma_reg_t'(cfg_index))
                REG_CENTER_X:  center_x_reg  <= cfg_wdata[POS_BITS-1:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_wdata[POS_BITS-1:0];
                REG_CENTER_Z:  center_z_reg  <= cfg_wdata[POS_BITS-1:0];
                REG_RADIUS_SQ: radius_sq_reg <= cfg_wdata[RSQ_W-1:0];
                default: ;
            endcase
        end
    end

    // hold only when a closing particle would overwrite a result still waiting
    assign en      = !(dst_ctl.valid && dst_ctl.last && m_valid && !m_ready);
    assign s_ready = en;

    sma_dist #(
        .POS_BITS  (POS_BITS),
        .MASS_BITS (MASS_BITS)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_px     (s_px),
        .in_py     (s_py),
        .in_pz     (s_pz),
        .in_pmass  (s_pmass),
        .in_last   (s_last),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius_sq (radius_sq_reg),
        .out_ctl   (dst_ctl),
        .out_mass  (dst_mass)
    );

    sma_accum #(
        .MASS_BITS (MASS_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_ctl      (dst_ctl),
        .in_mass     (dst_mass),
        .out_ready   (m_ready),
        .out_valid   (m_valid),
        .out_mass_r1 (m_mass_r1),
        .out_mass_r2 (m_mass_r2),
        .out_mass_r4 (m_mass_r4),
        .out_mass_r8 (m_mass_r8),
        .out_count   (m_inner_count)
    );

    assign hits_outer   = dst_ctl.hits.r2 && dst_ctl.hits.r4 && dst_ctl.hits.r8;
    assign sums_ordered = (m_mass_r8 >= m_mass_r4) && (m_mass_r4 >= m_mass_r2)
                       && (m_mass_r2 >= m_mass_r1);

    `SMA_ASSERT_IMPL(a_hits_nested, dst_ctl.valid && dst_ctl.hits.r1, hits_outer)
    `SMA_ASSERT_IMPL(a_sums_ordered, m_valid, sums_ordered)
    `SMA_ASSERT_IMPL(a_empty_inner, m_valid && (m_inner_count == '0), m_mass_r1 == '0)
    `SMA_ASSERT_NEXT(a_pipe_hold, !en, $stable(dst_ctl) && $stable(dst_mass))

endmodule

@@ bench/tb_shell_mass_accumulator.sv @@
module tb_shell_mass_accumulator;
    import sma_pkg::*;

    localparam int POS_W          = POS_BITS_DEF;
    localparam int MASS_W         = MASS_BITS_DEF;
    localparam int RUN_LIMIT      = 600000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_ITEMS    = 200;
    localparam int PRESSURE_PHASE = 4;
    localparam int MAX_REPORTS    = 10;

    localparam logic [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
    localparam logic [CFG_W-1:0]  RSQ_MAX  = {RSQ_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
        logic [MASS_W-1:0] mass;
        logic              last;
    } particle_t;

    typedef struct packed {
        logic [SUM_W-1:0] r1;
        logic [SUM_W-1:0] r2;
        logic [SUM_W-1:0] r4;
        logic [SUM_W-1:0] r8;
        logic [CNT_W-1:0] count;
    } shell_sums_t;

    typedef enum logic {ROW_WRITE, ROW_PARTICLE} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        sma_reg_t         reg_idx;
        logic [CFG_W-1:0] reg_val;
        particle_t        part;
        logic             has_known;
        shell_sums_t      known;
    } dir_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [POS_W-1:0]     s_px      = '0;
    logic [POS_W-1:0]     s_py      = '0;
    logic [POS_W-1:0]     s_pz      = '0;
    logic [MASS_W-1:0]    s_pmass   = '0;
    logic                 s_last    = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [SUM_W-1:0]     m_mass_r1;
    logic [SUM_W-1:0]     m_mass_r2;
    logic [SUM_W-1:0]     m_mass_r4;
    logic [SUM_W-1:0]     m_mass_r8;
    logic [CNT_W-1:0]     m_inner_count;

    shell_mass_accumulator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_px          (s_px),
        .s_py          (s_py),
        .s_pz          (s_pz),
        .s_pmass       (s_pmass),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mass_r1     (m_mass_r1),
        .m_mass_r2     (m_mass_r2),
        .m_mass_r4     (m_mass_r4),
        .m_mass_r8     (m_mass_r8),
        .m_inner_count (m_inner_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [POS_W-1:0] hc_x     = '0;
    logic [POS_W-1:0] hc_y     = '0;
    logic [POS_W-1:0] hc_z     = '0;
    logic [RSQ_W-1:0] rsq_cur  = '0;
    shell_sums_t      open_sums = '0;
    shell_sums_t      halo_sums_due[$];
    dir_row_t         plan[$];

    int  mismatches = 0;
    int  cycles     = 0;
    int  burst_left = 0;
    bit  steady     = 1'b0;
    logic hold_req  = 1'b0;
    bit  hold_done  = 1'b0;
    int  hold_left  = 0;
    int  pat_age    = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    function automatic logic [SUM_W-1:0] mass_add(logic [SUM_W-1:0] acc,
                                                  logic [MASS_W-1:0] m);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(m);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [63:0] axis_sq(logic [POS_W-1:0] p, logic [POS_W-1:0] c);
        longint d;
        d = longint'($signed(p)) - longint'($signed(c));
        return 64'(d * d);
    endfunction

    function automatic void tally_particle(particle_t p, logic has_known,
                                           shell_sums_t known);
        logic [63:0] d2;
        logic [63:0] t1;
        d2 = axis_sq(p.px, hc_x) + axis_sq(p.py, hc_y) + axis_sq(p.pz, hc_z);
        t1 = 64'(rsq_cur);
        if (d2 < (t1 << SHIFT_R8)) open_sums.r8 = mass_add(open_sums.r8, p.mass);
        if (d2 < (t1 << SHIFT_R4)) open_sums.r4 = mass_add(open_sums.r4, p.mass);
        if (d2 < (t1 << SHIFT_R2)) open_sums.r2 = mass_add(open_sums.r2, p.mass);
        if (d2 < t1) begin
            open_sums.r1 = mass_add(open_sums.r1, p.mass);
            if (open_sums.count != {CNT_W{1'b1}})
                open_sums.count = open_sums.count + CNT_W'(1);
        end
        if (p.last) begin
            halo_sums_due.push_back(has_known ? known : open_sums);
            open_sums = '0;
        end
    endfunction

    function automatic logic [CFG_W-1:0] pos_word(logic [POS_W-1:0] v);
        return {{(CFG_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return POS_MIN;
            1: return POS_MAX;
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] near_offset(int k);
        int off;
        off = $signed($urandom) >>> (31 - k);
        return off[POS_W-1:0];
    endfunction

    function automatic void plan_write(sma_reg_t idx, logic [CFG_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        plan.push_back(r);
    endfunction

    function automatic void plan_part(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [POS_W-1:0] z, logic [MASS_W-1:0] m,
                                      logic last, logic has_known, shell_sums_t known);
        dir_row_t r;
        r = '0;
        r.kind = ROW_PARTICLE;
        r.part = '{px: x, py: y, pz: z, mass: m, last: last};
        r.has_known = has_known;
        r.known = known;
        plan.push_back(r);
    endfunction

    task automatic write_reg(sma_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_CENTER_X:  hc_x = val[POS_W-1:0];
            REG_CENTER_Y:  hc_y = val[POS_W-1:0];
            REG_CENTER_Z:  hc_z = val[POS_W-1:0];
            REG_RADIUS_SQ: rsq_cur = val[RSQ_W-1:0];
            default: ;
        endcase
    endtask

    task automatic offer(particle_t p, logic has_known, shell_sums_t known);
        int gap;
        cfg_we <= 1'b0;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_px <= p.px;
        s_py <= p.py;
        s_pz <= p.pz;
        s_pmass <= p.mass;
        s_last <= p.last;
        do @(posedge aclk); while (!s_ready);
        tally_particle(p, has_known, known);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (halo_sums_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                pat_age = $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom) | 16'h0001;
                    2: stall_pat = 16'($urandom | $urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
            pat_age--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            m_ready <= stall_pat[0];
        end
    end

    always @(posedge aclk) begin : watch_results
        shell_sums_t got;
        shell_sums_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_mass_r1, m_mass_r2, m_mass_r4, m_mass_r8, m_inner_count};
            if (halo_sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing due: r1=%h r2=%h r4=%h r8=%h n=%h",
                             got.r1, got.r2, got.r4, got.r8, got.count);
            end else begin
                want = halo_sums_due.pop_front();
                if (got.r1 !== want.r1 || got.r2 !== want.r2 || got.r4 !== want.r4 ||
                    got.r8 !== want.r8 || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp r1=%h r2=%h r4=%h r8=%h n=%h",
                                  " got r1=%h r2=%h r4=%h r8=%h n=%h"},
                                 want.r1, want.r2, want.r4, want.r8, want.count,
                                 got.r1, got.r2, got.r4, got.r8, got.count);
                end
            end
        end
    end

    initial begin
        particle_t        p;
        logic [CFG_W-1:0] rsq_pick;
        int               odds;
        int               spread;
        int               k;
        int               i;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero radius after reset: nothing lands in any shell
        plan_part(POS_MIN, POS_MAX, '0, MASS_MAX, 1'b0, 1'b0, '0);
        plan_part('0, '0, '0, MASS_MAX, 1'b1, 1'b1, '0);
        // shell boundaries are strict: after one at the centre, each particle sits exactly on one radius
        plan_write(REG_RADIUS_SQ, 44'd100);
        plan_part('0, '0, '0, 32'd1, 1'b0, 1'b0, '0);
        plan_part(24'd10, '0, '0, 32'd2, 1'b0, 1'b0, '0);
        plan_part('0, -24'sd20, '0, 32'd4, 1'b0, 1'b0, '0);
        plan_part('0, '0, 24'd40, 32'd8, 1'b0, 1'b0, '0);
        plan_part('0, '0, 24'd80, 32'd16, 1'b1, 1'b1, '{1, 3, 7, 15, 1});
        // extreme centres and radius: largest possible distances
        plan_write(REG_CENTER_X, pos_word(POS_MAX));
        plan_write(REG_CENTER_Y, pos_word(POS_MAX));
        plan_write(REG_CENTER_Z, pos_word(POS_MAX));
        plan_write(REG_RADIUS_SQ, RSQ_MAX);
        plan_part(POS_MIN, POS_MIN, POS_MIN, MASS_MAX, 1'b0, 1'b0, '0);
        plan_part(POS_MAX, POS_MAX, POS_MAX, '0, 1'b0, 1'b0, '0);
        plan_part(POS_MAX, POS_MAX, POS_MAX, MASS_MAX, 1'b1, 1'b0, '0);
        plan_write(REG_CENTER_X, pos_word(POS_MIN));
        plan_write(REG_CENTER_Y, pos_word(POS_MIN));
        plan_write(REG_CENTER_Z, pos_word(POS_MIN));
        plan_write(REG_RADIUS_SQ, 44'd1);
        plan_part(POS_MIN, POS_MIN, POS_MIN, MASS_MAX, 1'b0, 1'b0, '0);
        plan_part(POS_MIN + POS_W'(1), POS_MIN, POS_MIN, 32'd1, 1'b1, 1'b0, '0);
        // hold open sums across a centre move
        plan_write(REG_CENTER_X, '0);
        plan_write(REG_CENTER_Y, '0);
        plan_write(REG_CENTER_Z, '0);
        plan_part('0, '0, '0, 32'd7, 1'b0, 1'b0, '0);
        plan_write(REG_CENTER_X, 44'd100);
        plan_part('0, '0, '0, 32'd9, 1'b1, 1'b1, '{7, 7, 7, 7, 1});

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (i > 0 && plan[i-1].kind == ROW_PARTICLE) settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                offer(plan[i].part, plan[i].has_known, plan[i].known);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_CENTER_X, pos_word(pick_coord()));
            if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_CENTER_Y, pos_word(pick_coord()));
            if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(REG_CENTER_Z, pos_word(pick_coord()));
            case ($urandom_range(0, 7))
                0: rsq_pick = '0;
                1: rsq_pick = RSQ_MAX;
                default: rsq_pick = CFG_W'({$urandom, $urandom} >> $urandom_range(14, 63));
            endcase
            write_reg(REG_RADIUS_SQ, rsq_pick);
            spread = $clog2(64'(rsq_cur) + 64'd1) / 2;
            odds = $urandom_range(2, 40);
            steady = ($urandom_range(0, 3) == 0);
            if (ph == PRESSURE_PHASE) begin
                odds = 2;
                steady = 1'b1;
                hold_req <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 6))
                    0: begin
                        p.px = POS_W'($urandom);
                        p.py = POS_W'($urandom);
                        p.pz = POS_W'($urandom);
                    end
                    default: begin
                        k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, POS_W - 1)
                                                        : spread + $urandom_range(0, 4) - 2;
                        if (k < 0) k = 0;
                        if (k > POS_W - 1) k = POS_W - 1;
                        p.px = hc_x + near_offset(k);
                        p.py = hc_y + near_offset(k);
                        p.pz = hc_z + near_offset(k);
                    end
                endcase
                case ($urandom_range(0, 7))
                    0: p.mass = '0;
                    1: p.mass = MASS_MAX;
                    2: p.mass = $urandom_range(0, 15);
                    default: p.mass = $urandom;
                endcase
                p.last = (n == PHASE_ITEMS - 1) ? 1'($urandom_range(0, 1))
                                                : ($urandom_range(1, odds) == 1);
                offer(p, 1'b0, '0);
            end
            steady = 1'b0;
        end

        settle();

        if (mismatches == 0 && halo_sums_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
